// ===== rtl/lkv_pkg.sv =====
// Package for the LRU key/value cache: field widths, request codes and the
// command/status bundles between controller and datapath. No dependencies.
package lkv_pkg;

  // Fixed width of the payload and reported key fields
  localparam int FIELD_W = 32;

  // Request codes carried on the mode field
  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // capture a new item and clear the scan trackers
    logic scan;    // read the entry at the scan index and advance
    logic update;  // commit writes, age ranks and the result item
  } lkv_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic scan_last;  // scan index points at the last entry
  } lkv_sts_t;

endpackage

// ===== rtl/lkv_ctrl.sv =====
// Controller state machine for the LRU key/value cache.
// Depends on lkv_pkg for the command and status bundles.
module lkv_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  lkv_pkg::lkv_sts_t sts,
  output lkv_pkg::lkv_cmd_t cmd
);
  import lkv_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_UPDATE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Sequence one item: scan all entries, finish the last compare, commit
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Decode commands from the current state
  assign busy       = (state_r != ST_IDLE);
  assign cmd.load   = (state_r == ST_IDLE) && start;
  assign cmd.scan   = (state_r == ST_SCAN);
  assign cmd.update = (state_r == ST_UPDATE);

endmodule

// ===== rtl/lkv_datapath.sv =====
// Datapath for the LRU key/value cache: key and payload memories, valid bits,
// age ranks, the scan trackers and the result registers.
// Depends on lkv_pkg for widths, request codes and the command bundle.
module lkv_datapath #(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lkv_pkg::lkv_cmd_t            cmd,
  output lkv_pkg::lkv_sts_t            sts,
  input  logic                         in_mode,
  input  logic [lkv_pkg::FIELD_W-1:0]  in_key,
  input  logic [lkv_pkg::FIELD_W-1:0]  in_payload,
  output logic                         out_valid,
  output logic                         out_hit,
  output logic [lkv_pkg::FIELD_W-1:0]  out_payload_out,
  output logic                         out_evicted,
  output logic [lkv_pkg::FIELD_W-1:0]  out_evicted_key
);
  import lkv_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [IDX_W-1:0] RANK_MAX = IDX_W'(ENTRIES - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

  // Storage
  logic [KEY_BITS-1:0] key_mem [ENTRIES];
  logic [FIELD_W-1:0]  pay_mem [ENTRIES];
  logic [ENTRIES-1:0]  valid_r;
  logic [IDX_W-1:0]    rank_r [ENTRIES];
  logic [CNT_W-1:0]    count_r;

  // Captured item
  logic                req_mode_r;
  logic [KEY_BITS-1:0] req_key_r;
  logic [FIELD_W-1:0]  req_pay_r;
  logic [KEY_BITS-1:0] key_ext;

  // Scan and compare stage
  logic [IDX_W-1:0]    scan_idx_r;
  logic [IDX_W-1:0]    cmp_idx_r;
  logic                cmp_en_r;
  logic [KEY_BITS-1:0] key_q;
  logic [FIELD_W-1:0]  pay_q;
  logic                cmp_valid;
  logic [IDX_W-1:0]    cmp_rank;

  // Trackers
  logic                match_found_r;
  logic [IDX_W-1:0]    match_idx_r;
  logic [IDX_W-1:0]    match_rank_r;
  logic [FIELD_W-1:0]  match_pay_r;
  logic                free_found_r;
  logic [IDX_W-1:0]    free_idx_r;
  logic [IDX_W-1:0]    victim_idx_r;
  logic [KEY_BITS-1:0] victim_key_r;
  logic [FIELD_W-1:0]  victim_key32;

  // Update decode
  logic                is_insert;
  logic                do_promote;
  logic                new_key;
  logic                do_evict;
  logic [IDX_W-1:0]    tgt_idx;
  logic [IDX_W-1:0]    tgt_rank;

  // Result registers
  logic                out_valid_r;
  logic                out_hit_r;
  logic [FIELD_W-1:0]  out_payload_r;
  logic                out_evicted_r;
  logic [FIELD_W-1:0]  out_evicted_key_r;

  // Fit the key field to the stored key width and back
  generate
    if (KEY_BITS > FIELD_W) begin : g_key_wide
      assign key_ext      = {{(KEY_BITS - FIELD_W){1'b0}}, in_key};
      assign victim_key32 = victim_key_r[FIELD_W-1:0];
    end else if (KEY_BITS == FIELD_W) begin : g_key_same
      assign key_ext      = in_key;
      assign victim_key32 = victim_key_r;
    end else begin : g_key_narrow
      assign key_ext      = in_key[KEY_BITS-1:0];
      assign victim_key32 = {{(FIELD_W - KEY_BITS){1'b0}}, victim_key_r};
    end
  endgenerate

  // Capture the item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_mode_r <= in_mode;
      req_key_r  <= key_ext;
      req_pay_r  <= in_payload;
    end
  end

  // Advance the scan index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      cmp_en_r   <= 1'b0;
    end else begin
      cmp_en_r <= cmd.scan;
      if (cmd.load) begin
        scan_idx_r <= '0;
      end else if (cmd.scan) begin
        scan_idx_r <= scan_idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= scan_idx_r;
  end

  assign sts.scan_last = (scan_idx_r == LAST_IDX);

  // Update decode: pick the entry to touch and its current rank
  assign is_insert  = (req_mode_r == MODE_INSERT);
  assign new_key    = is_insert && !match_found_r;
  assign do_evict   = new_key && !free_found_r;
  assign do_promote = match_found_r || is_insert;

  always_comb begin
    if (match_found_r) begin
      tgt_idx  = match_idx_r;
      tgt_rank = match_rank_r;
    end else if (free_found_r) begin
      tgt_idx  = free_idx_r;
      tgt_rank = count_r[IDX_W-1:0];
    end else begin
      tgt_idx  = victim_idx_r;
      tgt_rank = RANK_MAX;
    end
  end

  // Key and payload memories: read at the scan index, write on commit
  always_ff @(posedge clk) begin
    if (cmd.update && new_key) begin
      key_mem[tgt_idx] <= req_key_r;
    end
    key_q <= key_mem[scan_idx_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.update && is_insert) begin
      pay_mem[tgt_idx] <= req_pay_r;
    end
    pay_q <= pay_mem[scan_idx_r];
  end

  // Compare one entry per cycle
  assign cmp_valid = valid_r[cmp_idx_r];
  assign cmp_rank  = rank_r[cmp_idx_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
    end else if (cmd.load) begin
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
    end else if (cmp_en_r) begin
      if (cmp_valid && (key_q == req_key_r) && !match_found_r) begin
        match_found_r <= 1'b1;
      end
      if (!cmp_valid && !free_found_r) begin
        free_found_r <= 1'b1;
      end
    end
  end

  // Hold index, rank and data of the first hit, first hole and the oldest entry
  always_ff @(posedge clk) begin
    if (cmp_en_r) begin
      if (cmp_valid && (key_q == req_key_r) && !match_found_r) begin
        match_idx_r  <= cmp_idx_r;
        match_rank_r <= cmp_rank;
        match_pay_r  <= pay_q;
      end
      if (!cmp_valid && !free_found_r) begin
        free_idx_r <= cmp_idx_r;
      end
      if (cmp_valid && (cmp_rank == RANK_MAX)) begin
        victim_idx_r <= cmp_idx_r;
        victim_key_r <= key_q;
      end
    end
  end

  // Mark a newly filled entry valid; on a hit or insert, age every younger entry and make the touched entry most recent
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else if (cmd.update) begin
      if (new_key && free_found_r) begin
        valid_r[tgt_idx] <= 1'b1;
        count_r          <= count_r + CNT_W'(1);
      end
      if (do_promote) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (IDX_W'(i) == tgt_idx) begin
            rank_r[i] <= '0;
          end else if (valid_r[i] && (rank_r[i] < tgt_rank)) begin
            rank_r[i] <= rank_r[i] + IDX_W'(1);
          end
        end
      end
    end
  end

  // Register the result item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.update;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_hit_r         <= is_insert || match_found_r;
      out_payload_r     <= is_insert     ? req_pay_r   :
                           match_found_r ? match_pay_r : '0;
      out_evicted_r     <= do_evict;
      out_evicted_key_r <= do_evict ? victim_key32 : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_payload_out = out_payload_r;
  assign out_evicted     = out_evicted_r;
  assign out_evicted_key = out_evicted_key_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count exceeds capacity");

  a_count_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(count_r))
    else $error("entry count disagrees with valid bits");

  a_insert_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.update && is_insert) |=> (out_valid && out_hit))
    else $error("insert did not report a hit");

  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_evicted) |-> (count_r == FULL_CNT))
    else $error("eviction while the cache had free entries");

endmodule

// ===== rtl/lru_key_value_cache.sv =====
// LRU key/value cache: each accepted item is compared against every entry,
// reading one key/payload entry per cycle through the memory read port, and
// then committed; a new item is taken only once the previous one has committed.
// Results are strobed for one cycle on out_valid; the receiver cannot stall.
// Synchronous active-low reset empties the cache (valid bits, ranks, count).
// Top level: joins lkv_ctrl and lkv_datapath; depends on lkv_pkg.
module lru_key_value_cache #(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_mode,
  input  logic [lkv_pkg::FIELD_W-1:0]  in_key,
  input  logic [lkv_pkg::FIELD_W-1:0]  in_payload,
  output logic                         out_valid,
  output logic                         out_hit,
  output logic [lkv_pkg::FIELD_W-1:0]  out_payload_out,
  output logic                         out_evicted,
  output logic [lkv_pkg::FIELD_W-1:0]  out_evicted_key
);
  import lkv_pkg::*;

  lkv_cmd_t cmd;
  lkv_sts_t sts;

  // Sequence each item
  lkv_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Store, search and age the entries
  lkv_datapath #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_mode         (in_mode),
    .in_key          (in_key),
    .in_payload      (in_payload),
    .out_valid       (out_valid),
    .out_hit         (out_hit),
    .out_payload_out (out_payload_out),
    .out_evicted     (out_evicted),
    .out_evicted_key (out_evicted_key)
  );

endmodule

// ===== test/lru_key_value_cache_tb.sv =====
// Self-checking testbench for lru_key_value_cache: directed and random lookups
// and inserts, with results checked against an LRU cache model in a small class.
// Depends on lkv_pkg and the lru_key_value_cache RTL.
module lru_key_value_cache_tb;
  import lkv_pkg::*;

  localparam int          ENTRIES     = 16;
  localparam int          KEY_BITS    = 32;
  localparam int          POOL_SIZE   = 24;
  localparam int          MAX_GAP     = 24;
  localparam int unsigned CYCLE_LIMIT = 200000;

  // One result item of the cache
  typedef struct {
    logic               hit;
    logic [FIELD_W-1:0] data;
    logic               evicted;
    logic [FIELD_W-1:0] victim;
  } cache_result_t;

  // Mirror of the cache contents plus the results still owed by the block
  class cache_mirror;
    logic [FIELD_W-1:0] slot_key[ENTRIES];
    logic [FIELD_W-1:0] slot_data[ENTRIES];
    bit                 slot_used[ENTRIES];
    int unsigned        slot_age[ENTRIES];
    int unsigned        used_count;
    cache_result_t      pending_results[$];
    int unsigned        mismatches;
    int unsigned        items;
    int unsigned        lookup_hits;
    int unsigned        lookup_misses;
    int unsigned        inserts;
    int unsigned        evictions;

    function new();
      foreach (slot_used[i]) begin
        slot_used[i] = 1'b0;
        slot_age[i]  = 0;
      end
      used_count    = 0;
      mismatches    = 0;
      items         = 0;
      lookup_hits   = 0;
      lookup_misses = 0;
      inserts       = 0;
      evictions     = 0;
    endfunction

    // Apply one accepted item to the mirror and queue its result
    function void note_request(logic mode, logic [FIELD_W-1:0] key,
                               logic [FIELD_W-1:0] data);
      cache_result_t r;
      int            idx;
      int            free_slot;
      int unsigned   best;
      int unsigned   rank;
      r.hit     = 1'b0;
      r.data    = '0;
      r.evicted = 1'b0;
      r.victim  = '0;
      items++;
      idx = -1;
      for (int i = 0; i < ENTRIES; i++)
        if (idx < 0 && slot_used[i] && slot_key[i] == key) idx = i;

      if (mode == MODE_LOOKUP) begin
        if (idx >= 0) begin
          r.hit  = 1'b1;
          r.data = slot_data[idx];
          lookup_hits++;
        end else begin
          lookup_misses++;
        end
      end else begin
        if (idx < 0) begin
          free_slot = -1;
          for (int i = 0; i < ENTRIES; i++)
            if (free_slot < 0 && !slot_used[i]) free_slot = i;
          if (free_slot < 0) begin
            // full: reuse the oldest entry, which starts out as the oldest rank
            best = 0;
            idx  = 0;
            for (int i = 0; i < ENTRIES; i++)
              if (slot_used[i] && slot_age[i] > best) begin
                best = slot_age[i];
                idx  = i;
              end
            r.evicted     = 1'b1;
            r.victim      = slot_key[idx];
            slot_age[idx] = ENTRIES - 1;
            evictions++;
          end else begin
            idx            = free_slot;
            slot_used[idx] = 1'b1;
            slot_age[idx]  = used_count;
            if (used_count < ENTRIES) used_count++;
          end
          slot_key[idx] = key;
        end
        slot_data[idx] = data;
        r.hit          = 1'b1;
        r.data         = data;
        inserts++;
      end

      // Touch the entry: everything younger than it ages by one
      if (idx >= 0) begin
        rank = slot_age[idx];
        for (int i = 0; i < ENTRIES; i++)
          if (slot_used[i] && i != idx && slot_age[i] < rank) slot_age[i]++;
        slot_age[idx] = 0;
      end
      pending_results.insert(pending_results.size(), r);
    endfunction

    // Compare one strobed result with the oldest expected one
    function void check_response(logic hit, logic [FIELD_W-1:0] data,
                                 logic evicted, logic [FIELD_W-1:0] victim);
      cache_result_t exp_r;
      if (pending_results.size() == 0) begin
        $error("result item with nothing expected: hit=%0d payload=%h", hit, data);
        mismatches++;
        return;
      end
      exp_r = pending_results[0];
      pending_results.delete(0);
      if (hit !== exp_r.hit) begin
        $error("out_hit: expected %0d, got %0d", exp_r.hit, hit);
        mismatches++;
      end
      if (data !== exp_r.data) begin
        $error("out_payload_out: expected %h, got %h", exp_r.data, data);
        mismatches++;
      end
      if (evicted !== exp_r.evicted) begin
        $error("out_evicted: expected %0d, got %0d", exp_r.evicted, evicted);
        mismatches++;
      end
      if (victim !== exp_r.victim) begin
        $error("out_evicted_key: expected %h, got %h", exp_r.victim, victim);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               start      = 1'b0;
  logic               busy;
  logic               in_mode    = MODE_LOOKUP;
  logic [FIELD_W-1:0] in_key     = '0;
  logic [FIELD_W-1:0] in_payload = '0;
  logic               out_valid;
  logic               out_hit;
  logic [FIELD_W-1:0] out_payload_out;
  logic               out_evicted;
  logic [FIELD_W-1:0] out_evicted_key;

  cache_mirror        mirror;
  logic [FIELD_W-1:0] key_pool[POOL_SIZE];
  int unsigned        cycle_count = 0;

  lru_key_value_cache #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_key          (in_key),
    .in_payload      (in_payload),
    .out_valid       (out_valid),
    .out_hit         (out_hit),
    .out_payload_out (out_payload_out),
    .out_evicted     (out_evicted),
    .out_evicted_key (out_evicted_key)
  );

  // Clock: period 4
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Check every strobed result item
  always @(posedge clk) begin
    if (rst_n && out_valid)
      mirror.check_response(out_hit, out_payload_out, out_evicted, out_evicted_key);
  end

  // Present one item and hold it until the block accepts it
  task automatic send_request(logic mode, logic [FIELD_W-1:0] key,
                              logic [FIELD_W-1:0] data);
    start      <= 1'b1;
    in_mode    <= mode;
    in_key     <= key;
    in_payload <= data;
    do @(posedge clk); while (busy);
    mirror.note_request(mode, key, data);
  endtask

  // Drop start for a random stretch, pct times in a hundred
  task automatic pause_sender(int unsigned pct);
    int unsigned gap;
    if ($urandom_range(99) < pct) begin
      gap   = $urandom_range(MAX_GAP, 1);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Random traffic over a key pool a bit larger than the cache, to mix hits
  // and evictions, with some fresh keys that always miss or allocate
  task automatic run_random(int unsigned pct, int unsigned count);
    logic               mode;
    logic [FIELD_W-1:0] key;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    repeat (count) begin
      pause_sender(pct);
      mode = ($urandom_range(99) < 55) ? MODE_LOOKUP : MODE_INSERT;
      if ($urandom_range(99) < 20) key = $urandom;
      else key = key_pool[$urandom_range(POOL_SIZE - 1)];
      send_request(mode, key, $urandom);
    end
  endtask

  initial begin
    mirror = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: miss on empty, key and payload extremes, replace, fill, evict
    send_request(MODE_LOOKUP, '0, '1);
    send_request(MODE_INSERT, '0, '0);
    send_request(MODE_INSERT, '1, '1);
    send_request(MODE_LOOKUP, '0, '1);
    send_request(MODE_LOOKUP, '1, '0);
    send_request(MODE_INSERT, '0, 32'hA5A5_A5A5);
    send_request(MODE_LOOKUP, '0, '0);
    for (int i = 0; i < ENTRIES - 2; i++)
      send_request(MODE_INSERT, 32'h1000_0000 + i * 32'h0101_0101, $urandom);
    send_request(MODE_INSERT, 32'h5A5A_5A5A, 32'h0F0F_0F0F);
    send_request(MODE_LOOKUP, '1, '0);
    send_request(MODE_LOOKUP, '0, '0);
    send_request(MODE_INSERT, 32'h1234_5678, 32'h8765_4321);
    send_request(MODE_INSERT, 32'h1000_0000, '1);
    send_request(MODE_LOOKUP, 32'h1000_0000, '0);

    // Random: sender idling often, very often, then never
    run_random(33, 250);
    run_random(82, 250);
    run_random(0, 250);
    start <= 1'b0;

    // Drain, then watch for stray results
    while (mirror.outstanding() != 0) @(posedge clk);
    repeat (ENTRIES + 6) @(posedge clk);

    $display("Covered %0d items: %0d lookup hits, %0d lookup misses, %0d inserts,",
             mirror.items, mirror.lookup_hits, mirror.lookup_misses, mirror.inserts);
    $display("  %0d of the inserts evicted the oldest entry; %0d mismatches.",
             mirror.evictions, mirror.mismatches);
    if (mirror.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
